// ===== src/rclfp_pkg.sv =====
// Shared types, constants and the CRC-8 step for the RC link frame parser.
// Used by every module of the block; depends on nothing.
package rclfp_pkg;

	// Frame store geometry
	localparam int FRAME_BYTES   = 64;
	localparam int POS_W         = $clog2(FRAME_BYTES + 1);
	localparam int PAYLOAD_START = 3;
	localparam int NUM_CHANNELS  = 16;
	localparam int CHANNEL_BITS  = 11;
	localparam int CHAN_BYTES    = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
	localparam int CHAN_FLAT_W   = CHAN_BYTES * 8;
	localparam int CHAN_IDX_W    = $clog2(NUM_CHANNELS);
	localparam int PAY_IDX_W     = $clog2(CHAN_BYTES);
	localparam int BIT_OFF_W     = $clog2(CHAN_FLAT_W);

	// Queue between front and back
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// CRC-8 DVB-S2
	localparam logic [7:0] CRC_POLY = 8'hD5;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	// Configuration reset values
	localparam logic [7:0] SYNC_RESET    = 8'd200;
	localparam logic [7:0] CHTYPE_RESET  = 8'd22;
	localparam logic [5:0] MAXLEN_RESET  = 6'd62;
	localparam logic [7:0] MIN_LENGTH    = 8'd2;

	// APB register map
	localparam int PADDR_W = 4;
	typedef enum logic [1:0] {
		REG_SYNC   = 2'd0,
		REG_CHTYPE = 2'd1,
		REG_MAXLEN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sync_value;
		logic [7:0] channels_type;
		logic [5:0] max_length;
	} cfg_t;

	// One good frame handed from front to back
	typedef struct packed {
		logic [7:0]                      kind;
		logic                            is_chan;
		logic [CHAN_BYTES-1:0][7:0]      chan_data;
	} entry_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/rc_link_frame_parser.sv =====
// Top level of the RC link frame parser: APB configuration registers,
// front, queue and back. Depends on rclfp_pkg and the rclfp_* modules.
//
// Usage:
//   Byte channel (byte_valid/byte_ready, rx_byte): one received serial byte
//   per beat. The front takes one every cycle byte_ready is high; a frame is
//   [sync][length L][type][L-2 payload][crc], CRC-8 poly 0xD5, zero init.
//   Result channel (res_valid/res_ready): one beat per result. A good RC
//   channels frame gives 16 beats (channel 0..15, last on 15); any other
//   good frame gives one beat with has_channels 0. Bad frames give nothing.
//   A good frame is queued with its CRC byte; its results then leave by the
//   output register, one per cycle while res_ready is high. Bytes come in one
//   per cycle while byte_ready is high; a channels frame holds the back for 16 results.
//   A two-frame queue sits between front and back; byte_ready drops only
//   while it is full, so a stalled receiver stalls the byte side only once
//   two finished frames wait.
//   Reset clears position, CRC, captured channel bytes and the queue, and
//   loads sync 200, channels type 22, max length 62.
//   Registers: 0x0 sync_value, 0x4 channels_type, 0x8 max_length.
module rc_link_frame_parser
	import rclfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    byte_valid,
	output logic                    byte_ready,
	input  logic [7:0]              rx_byte,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [7:0]              frame_kind,
	output logic                    has_channels,
	output logic [CHAN_IDX_W-1:0]   channel_index,
	output logic [CHANNEL_BITS-1:0] channel_value,
	output logic                    last
);

	cfg_t      cfg_q;
	logic      cfg_wr;
	reg_idx_t  reg_idx;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    head;
	q_status_t q_stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value    <= SYNC_RESET;
			cfg_q.channels_type <= CHTYPE_RESET;
			cfg_q.max_length    <= MAXLEN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SYNC:   cfg_q.sync_value    <= pwdata[7:0];
				REG_CHTYPE: cfg_q.channels_type <= pwdata[7:0];
				REG_MAXLEN: cfg_q.max_length    <= pwdata[5:0];
				default:    cfg_q               <= cfg_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_SYNC:   prdata = {24'd0, cfg_q.sync_value};
			REG_CHTYPE: prdata = {24'd0, cfg_q.channels_type};
			REG_MAXLEN: prdata = {26'd0, cfg_q.max_length};
			default:    prdata = 32'd0;
		endcase
	end

	rclfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.rx_byte    (rx_byte),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	rclfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	rclfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.frame_kind    (frame_kind),
		.has_channels  (has_channels),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

endmodule

// ===== src/rclfp_front.sv =====
// Front part: sync hunt, length check, running CRC and channel byte capture.
// Pushes one entry per good frame into the queue. Depends on rclfp_pkg.
module rclfp_front
	import rclfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	input  q_status_t  q_stat,
	output logic       push,
	output entry_t     push_entry
);

	logic [POS_W-1:0]            wpos_q, wpos_d;
	logic [7:0]                  crc_q, crc_d;
	logic [7:0]                  len_q;
	logic [7:0]                  kind_q;
	logic [CHAN_BYTES-1:0][7:0]  pay_q, pay_d;

	logic                        accept;
	logic [POS_W-1:0]            pos_inc;
	logic [7:0]                  len_now;
	logic [8:0]                  end_pos;
	logic                        len_bad;
	logic                        in_pay;
	logic [PAY_IDX_W-1:0]        pay_idx;
	logic [POS_W-1:0]            pay_off;

	// Stall input only while the queue cannot take a finished frame
	assign byte_ready = !q_stat.full;
	assign accept     = byte_valid && byte_ready;

	assign pos_inc = wpos_q + POS_W'(1);
	assign len_now = (wpos_q == POS_W'(1)) ? rx_byte : len_q;
	assign end_pos = {1'b0, len_now} + 9'd2;
	assign len_bad = (len_now < MIN_LENGTH) || (len_now > {2'b00, cfg.max_length});
	assign in_pay  = (wpos_q >= POS_W'(PAYLOAD_START))
		&& (wpos_q < POS_W'(PAYLOAD_START + CHAN_BYTES));
	assign pay_off = wpos_q - POS_W'(PAYLOAD_START);
	assign pay_idx = pay_off[PAY_IDX_W-1:0];

	// Capture channel bytes, step position and CRC, detect frame end
	always_comb begin
		wpos_d = wpos_q;
		crc_d  = crc_q;
		pay_d  = pay_q;
		push   = 1'b0;
		if (accept && in_pay) begin
			pay_d[pay_idx] = rx_byte;
		end
		if (accept) begin
			priority if (wpos_q == '0) begin
				if (rx_byte == cfg.sync_value) begin
					wpos_d = POS_W'(1);
					crc_d  = 8'd0;
				end
			end else if (wpos_q >= POS_W'(FRAME_BYTES)) begin
				wpos_d = '0;
			end else if (len_bad) begin
				wpos_d = '0;
			end else if ({2'b00, pos_inc} < end_pos) begin
				wpos_d = pos_inc;
				if (pos_inc >= POS_W'(3)) begin
					crc_d = crc8_step(crc_q, rx_byte);
				end
			end else begin
				wpos_d = '0;
				push   = (crc_q == rx_byte);
			end
		end
	end

	assign push_entry.kind      = kind_q;
	assign push_entry.is_chan   = (kind_q == cfg.channels_type);
	assign push_entry.chan_data = pay_d;

	// Hold position, CRC and captured bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			crc_q  <= 8'd0;
			pay_q  <= '0;
		end else begin
			wpos_q <= wpos_d;
			crc_q  <= crc_d;
			pay_q  <= pay_d;
		end
	end

	// Latch length and type bytes as they pass
	always_ff @(posedge clk) begin
		if (accept && wpos_q == POS_W'(1)) begin
			len_q <= rx_byte;
		end
		if (accept && wpos_q == POS_W'(2)) begin
			kind_q <= rx_byte;
		end
	end

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= POS_W'(FRAME_BYTES))
		else $error("frame position beyond store");

	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (accept && wpos_q >= POS_W'(3) && wpos_d == '0))
		else $error("push without closing a frame");

endmodule

// ===== src/rclfp_queue.sv =====
// Short queue of good frames between the front and the back.
// Depends on rclfp_pkg for the entry type and depth.
module rclfp_queue
	import rclfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t q_stat
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Write the pushed frame
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

// ===== src/rclfp_back.sv =====
// Back part: unpacks queued frames into results, one per cycle while the
// receiver takes them, into an output register. Depends on rclfp_pkg.
module rclfp_back
	import rclfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  entry_t                 head,
	input  q_status_t              q_stat,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [7:0]             frame_kind,
	output logic                   has_channels,
	output logic [CHAN_IDX_W-1:0]  channel_index,
	output logic [CHANNEL_BITS-1:0] channel_value,
	output logic                   last
);

	logic [CHAN_IDX_W-1:0]   chan_q;
	logic                    out_valid_q;
	logic [CHAN_FLAT_W-1:0]  flat;
	logic [BIT_OFF_W-1:0]    bit_off;
	logic [CHANNEL_BITS-1:0] chan_val;
	logic                    load;
	logic                    final_res;

	// Channel k sits at bit 11*k of the captured bytes
	assign flat     = head.chan_data;
	assign bit_off  = BIT_OFF_W'(chan_q) * BIT_OFF_W'(CHANNEL_BITS);
	assign chan_val = flat[bit_off +: CHANNEL_BITS];

	assign load      = (!out_valid_q || res_ready) && !q_stat.empty;
	assign final_res = !head.is_chan || (chan_q == CHAN_IDX_W'(NUM_CHANNELS - 1));
	assign pop       = load && final_res;
	assign res_valid = out_valid_q;

	// Output register valid and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chan_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				chan_q      <= final_res ? '0 : chan_q + CHAN_IDX_W'(1);
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			frame_kind    <= head.kind;
			has_channels  <= head.is_chan;
			channel_index <= head.is_chan ? chan_q : '0;
			channel_value <= head.is_chan ? chan_val : '0;
			last          <= final_res;
		end
	end

	a_last_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && has_channels) |->
			(last == (channel_index == CHAN_IDX_W'(NUM_CHANNELS - 1))))
		else $error("last flag out of step with channel index");

	a_chan_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (chan_q == '0))
		else $error("channel counter not cleared after frame");

endmodule
